/* rtl/sha1_block_compress_assert.svh */
// Assertion macros shared by the block's checking code.
`ifndef SHA1_BLOCK_COMPRESS_ASSERT_SVH
`define SHA1_BLOCK_COMPRESS_ASSERT_SVH

// Checked on every rising edge of clock while reset is low.
`define SBC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every rising edge of clock, reset included.
`define SBC_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* rtl/sha1bc_pkg.sv */
package sha1bc_pkg;

   localparam int unsigned WordWidth  = 32;
   localparam int unsigned BlockWords = 16;
   localparam int unsigned NumRounds  = 80;
   localparam int unsigned GroupLen   = 20;
   localparam int unsigned CountWidth = $clog2(BlockWords);
   localparam int unsigned RoundWidth = $clog2(NumRounds);

   localparam int unsigned TapT3  = BlockWords - 3;
   localparam int unsigned TapT8  = BlockWords - 8;
   localparam int unsigned TapT14 = BlockWords - 14;

   localparam logic [CountWidth-1:0] LastWord  = CountWidth'(BlockWords - 1);
   localparam logic [RoundWidth-1:0] LastRound = RoundWidth'(NumRounds - 1);

   localparam logic [WordWidth-1:0] Iv0 = 32'h6745_2301;
   localparam logic [WordWidth-1:0] Iv1 = 32'hEFCD_AB89;
   localparam logic [WordWidth-1:0] Iv2 = 32'h98BA_DCFE;
   localparam logic [WordWidth-1:0] Iv3 = 32'h1032_5476;
   localparam logic [WordWidth-1:0] Iv4 = 32'hC3D2_E1F0;

   localparam logic [WordWidth-1:0] K0 = 32'h5A82_7999;
   localparam logic [WordWidth-1:0] K1 = 32'h6ED9_EBA1;
   localparam logic [WordWidth-1:0] K2 = 32'h8F1B_BCDC;
   localparam logic [WordWidth-1:0] K3 = 32'hCA62_C1D6;

   typedef enum logic [1:0] {
      GRP_CHOOSE,
      GRP_PARITY_LO,
      GRP_MAJORITY,
      GRP_PARITY_HI
   } group_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ROUND,
      ST_FINAL
   } state_type;

   typedef struct packed {
      logic [WordWidth-1:0] msg_word;
      logic                 start_message;
   } req_type;

   typedef struct packed {
      logic [WordWidth-1:0] hash_a;
      logic [WordWidth-1:0] hash_b;
      logic [WordWidth-1:0] hash_c;
      logic [WordWidth-1:0] hash_d;
      logic [WordWidth-1:0] hash_e;
   } rsp_type;

   typedef struct packed {
      logic      busy;
      logic      step;
      logic      first16;
      group_type grp;
      logic      fin;
   } ctrl_type;

   localparam rsp_type InitHash = '{hash_a: Iv0, hash_b: Iv1, hash_c: Iv2,
                                    hash_d: Iv3, hash_e: Iv4};

   function automatic logic [WordWidth-1:0] round_const(input group_type grp);
      logic [WordWidth-1:0] k;
      case (grp)
         GRP_CHOOSE:    k = K0;
         GRP_PARITY_LO: k = K1;
         GRP_MAJORITY:  k = K2;
         GRP_PARITY_HI: k = K3;
         default:       k = K0;
      endcase
      return k;
   endfunction

   function automatic logic [WordWidth-1:0] rotl1(input logic [WordWidth-1:0] x);
      return {x[WordWidth-2:0], x[WordWidth-1]};
   endfunction

   function automatic logic [WordWidth-1:0] rotl5(input logic [WordWidth-1:0] x);
      return {x[WordWidth-6:0], x[WordWidth-1 -: 5]};
   endfunction

   function automatic logic [WordWidth-1:0] rotl30(input logic [WordWidth-1:0] x);
      return {x[1:0], x[WordWidth-1:2]};
   endfunction

endpackage

/* rtl/sha1_block_compress.sv */
// Words enter one per cycle while req_stall is low; once a block's sixteenth word is accepted,
// its rounds run in turn on the single round unit, followed by the chaining add, and no
// word is taken until that is done; the result then appears on rsp_data with rsp_valid.
// Reset (synchronous, active high) loads the initial hash, clears the word counter and
// drops any pending result; the message word window holds no valid data until written.
`include "sha1_block_compress_assert.svh"

module sha1_block_compress (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  sha1bc_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output sha1bc_pkg::rsp_type rsp_data
);
   import sha1bc_pkg::*;

   ctrl_type              ctl;
   rsp_type               chain_ff, chain_in;
   rsp_type               rsp_data_ff, rsp_data_in;
   rsp_type               work;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CountWidth-1:0] word_count_ff, word_count_in;
   logic [WordWidth-1:0]  w_cur;
   logic                  req_accept;
   logic                  go;

   assign req_stall  = ctl.busy || (rsp_valid_ff && (word_count_ff == LastWord));
   assign req_accept = req_valid && !req_stall;
   assign go         = req_accept && !req_data.start_message && (word_count_ff == LastWord);

   always_comb begin
      chain_in      = chain_ff;
      word_count_in = word_count_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      if (req_accept) begin
         if (req_data.start_message) begin
            chain_in      = InitHash;
            word_count_in = CountWidth'(1);
         end else begin
            word_count_in = word_count_ff + 1'b1;
         end
      end
      if (ctl.fin) begin
         chain_in.hash_a = chain_ff.hash_a + work.hash_a;
         chain_in.hash_b = chain_ff.hash_b + work.hash_b;
         chain_in.hash_c = chain_ff.hash_c + work.hash_c;
         chain_in.hash_d = chain_ff.hash_d + work.hash_d;
         chain_in.hash_e = chain_ff.hash_e + work.hash_e;
         rsp_data_in     = chain_in;
         rsp_valid_in    = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff      <= InitHash;
         word_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         chain_ff      <= chain_in;
         word_count_ff <= word_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   sha1bc_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .go    (go),
      .ctl   (ctl)
   );

   sha1bc_sched u_sched (
      .clock   (clock),
      .word_en (req_accept),
      .word_in (req_data.msg_word),
      .ctl     (ctl),
      .w_out   (w_cur)
   );

   sha1bc_round u_round (
      .clock (clock),
      .load  (go),
      .chain (chain_ff),
      .ctl   (ctl),
      .w_in  (w_cur),
      .work  (work)
   );

   `SBC_ASSERT(a_busy_stalls, ctl.busy |-> req_stall, "input taken during compression")
   `SBC_ASSERT(a_block_starts_rounds, go |=> (ctl.step && ctl.first16), "rounds not started")
   `SBC_ASSERT(a_result_from_final, $rose(rsp_valid_ff) |-> $past(ctl.fin), "stray result")
   `SBC_ASSERT(a_no_overwrite, (ctl.fin && !reset) |-> !$past(rsp_valid_ff && go), "overwrite")

endmodule

/* rtl/sha1bc_ctrl.sv */
module sha1bc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                go,
   output sha1bc_pkg::ctrl_type ctl
);
   import sha1bc_pkg::*;

   state_type              state_ff, state_in;
   logic [RoundWidth-1:0]  rnd_ff, rnd_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rnd_ff   <= '0;
      end else begin
         state_ff <= state_in;
         rnd_ff   <= rnd_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      rnd_in   = rnd_ff;
      case (state_ff)
         ST_IDLE: begin
            rnd_in = '0;
            if (go) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            rnd_in = rnd_ff + 1'b1;
            if (rnd_ff == LastRound) begin
               state_in = ST_FINAL;
               rnd_in   = '0;
            end
         end
         ST_FINAL: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
            rnd_in   = '0;
         end
      endcase
   end

   always_comb begin
      ctl         = '0;
      ctl.first16 = (rnd_ff < RoundWidth'(BlockWords));
      if (rnd_ff < RoundWidth'(GroupLen)) begin
         ctl.grp = GRP_CHOOSE;
      end else if (rnd_ff < RoundWidth'(2 * GroupLen)) begin
         ctl.grp = GRP_PARITY_LO;
      end else if (rnd_ff < RoundWidth'(3 * GroupLen)) begin
         ctl.grp = GRP_MAJORITY;
      end else begin
         ctl.grp = GRP_PARITY_HI;
      end
      case (state_ff)
         ST_IDLE: begin
            ctl.busy = 1'b0;
         end
         ST_ROUND: begin
            ctl.busy = 1'b1;
            ctl.step = 1'b1;
         end
         ST_FINAL: begin
            ctl.busy = 1'b1;
            ctl.fin  = 1'b1;
         end
         default: begin
            ctl.busy = 1'b1;
         end
      endcase
   end

endmodule

/* rtl/sha1bc_sched.sv */
module sha1bc_sched (
   input  logic                                clock,
   input  logic                                word_en,
   input  logic [sha1bc_pkg::WordWidth-1:0]    word_in,
   input  sha1bc_pkg::ctrl_type                ctl,
   output logic [sha1bc_pkg::WordWidth-1:0]    w_out
);
   import sha1bc_pkg::*;

   logic [BlockWords-1:0][WordWidth-1:0] win_ff, win_in;
   logic [WordWidth-1:0]                 expanded;
   logic [WordWidth-1:0]                 shift_word;

   assign expanded = rotl1(win_ff[TapT3] ^ win_ff[TapT8] ^ win_ff[TapT14] ^ win_ff[0]);
   assign w_out    = ctl.first16 ? win_ff[0] : expanded;

   always_comb begin
      shift_word = word_en ? word_in : w_out;
      win_in     = win_ff;
      if (word_en || ctl.step) begin
         win_in = {shift_word, win_ff[BlockWords-1:1]};
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
   end

endmodule

/* rtl/sha1bc_round.sv */
module sha1bc_round (
   input  logic                             clock,
   input  logic                             load,
   input  sha1bc_pkg::rsp_type              chain,
   input  sha1bc_pkg::ctrl_type             ctl,
   input  logic [sha1bc_pkg::WordWidth-1:0] w_in,
   output sha1bc_pkg::rsp_type              work
);
   import sha1bc_pkg::*;

   rsp_type              work_ff, work_in;
   logic [WordWidth-1:0] f_val;
   logic [WordWidth-1:0] sum;

   always_comb begin
      case (ctl.grp)
         GRP_CHOOSE: begin
            f_val = (work_ff.hash_b & work_ff.hash_c) | (~work_ff.hash_b & work_ff.hash_d);
         end
         GRP_MAJORITY: begin
            f_val = (work_ff.hash_b & work_ff.hash_c) | (work_ff.hash_b & work_ff.hash_d)
                  | (work_ff.hash_c & work_ff.hash_d);
         end
         default: begin
            f_val = work_ff.hash_b ^ work_ff.hash_c ^ work_ff.hash_d;
         end
      endcase
   end

   assign sum = rotl5(work_ff.hash_a) + f_val + work_ff.hash_e + w_in + round_const(ctl.grp);

   always_comb begin
      work_in = work_ff;
      if (load) begin
         work_in = chain;
      end else if (ctl.step) begin
         work_in.hash_a = sum;
         work_in.hash_b = work_ff.hash_a;
         work_in.hash_c = rotl30(work_ff.hash_b);
         work_in.hash_d = work_ff.hash_c;
         work_in.hash_e = work_ff.hash_d;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
   end

   assign work = work_ff;

endmodule
